[design/integer_literal_parser_defines.svh]
// Assertion macros for the integer literal parser.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define ILP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilp check failed");
`define ILP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilp check failed");
`else
`define ILP_ASSERT_NOW(lbl, ante, cons)
`define ILP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/ilp_pkg.sv]
// Shared types, widths and character codes for the integer literal parser.
// No dependencies.
package ilp_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;
    localparam int CHAR_WIDTH  = 8;

    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  last_char;
    } ilp_char_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] acc;
        logic                   negative;
        logic                   zero;
        logic                   error;
    } ilp_raw_t;

    function automatic logic is_dec(logic [CHAR_WIDTH-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // digit value 0..15, or NO_DIGIT
    function automatic logic [4:0] digit_of(logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] t;
        begin
            t = CHAR_WIDTH'(NO_DIGIT);
            if (is_dec(c))
                t = c - CH_ZERO;
            else if ((c >= CH_LA) && (c <= CH_LF))
                t = c - CH_LA + 8'd10;
            else if ((c >= CH_UA) && (c <= CH_UF))
                t = c - CH_UA + 8'd10;
            return t[4:0];
        end
    endfunction

endpackage

[design/ilp_in_reg.sv]
// Input register stage of the integer literal parser.
// Depends on ilp_pkg.
module ilp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ilp_pkg::ilp_char_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ilp_pkg::ilp_char_t out_data
);

    logic               valid_reg;
    ilp_pkg::ilp_char_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

[design/ilp_parser.sv]
// Per-character parse state machine and raw result register.
// Depends on ilp_pkg and integer_literal_parser_defines.svh.
`include "integer_literal_parser_defines.svh"
module ilp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ilp_pkg::ilp_char_t in_data,
    output logic               raw_valid,
    input  logic               raw_ready,
    output ilp_pkg::ilp_raw_t  raw_data
);

    localparam int VW = ilp_pkg::VALUE_WIDTH;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_AFTER_SIGN,
        MODE_SECOND,
        MODE_DEC,
        MODE_BIN,
        MODE_HEX,
        MODE_SKIP
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [VW-1:0]     acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [7:0]        pend_reg, pend_next;
    logic              err_reg, err_next;
    logic              raw_valid_reg;
    ilp_pkg::ilp_raw_t raw_reg, raw_next;

    logic [7:0]    c;
    logic [4:0]    d;
    logic [4:0]    dp;
    logic          bad;
    logic [VW-1:0] scaled;
    logic [7:0]    pair;
    logic [4:0]    d_fin;
    logic          fin_err;
    logic [VW-1:0] fin_acc;
    logic          take;

    assign c  = in_data.char_code;
    assign d  = ilp_pkg::digit_of(c);
    assign dp = ilp_pkg::digit_of(pend_reg);

    assign in_ready  = !(in_data.last_char && raw_valid_reg && !raw_ready);
    assign take      = in_valid && in_ready;
    assign raw_valid = raw_valid_reg;
    assign raw_data  = raw_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_DEC: scaled = (acc_reg << 3) + (acc_reg << 1);
            MODE_BIN: scaled = acc_reg << 1;
            default:  scaled = acc_reg << 4;
        endcase
        bad  = (d == ilp_pkg::NO_DIGIT) || ((mode_reg == MODE_BIN) && (d[4:1] != 4'd0));
        // two leading decimal digits, accumulator still zero here
        pair = ({3'b000, dp} << 3) + ({3'b000, dp} << 1) + {3'b000, d};

        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        pend_next = pend_reg;
        err_next  = err_reg;

        case (mode_reg)
            MODE_START:
            begin
                if (c == ilp_pkg::CH_MINUS)
                begin
                    neg_next  = 1'b1;
                    mode_next = MODE_AFTER_SIGN;
                end
                else
                begin
                    pend_next = c;
                    mode_next = MODE_SECOND;
                end
            end
            MODE_AFTER_SIGN:
            begin
                pend_next = c;
                mode_next = MODE_SECOND;
            end
            MODE_SECOND:
            begin
                if (ilp_pkg::is_dec(c))
                begin
                    mode_next = MODE_DEC;
                    if (dp == ilp_pkg::NO_DIGIT)
                        err_next = 1'b1;
                    else
                        acc_next = VW'(pair);
                end
                else if (pend_reg == ilp_pkg::CH_ZERO && c == ilp_pkg::CH_LB)
                    mode_next = MODE_BIN;
                else if (pend_reg == ilp_pkg::CH_ZERO && c == ilp_pkg::CH_LX)
                    mode_next = MODE_HEX;
                else
                    mode_next = MODE_SKIP;
            end
            MODE_DEC, MODE_BIN, MODE_HEX:
            begin
                if (!err_reg)
                begin
                    if (bad)
                        err_next = 1'b1;
                    else
                        acc_next = scaled + VW'(d);
                end
            end
            default:
            begin
            end
        endcase

        // a lone character is one decimal digit
        d_fin   = ilp_pkg::digit_of(pend_next);
        fin_err = err_next;
        fin_acc = acc_next;
        if (mode_next == MODE_SECOND)
        begin
            if (d_fin == ilp_pkg::NO_DIGIT)
                fin_err = 1'b1;
            else
                fin_acc = VW'(d_fin);
        end

        raw_next.acc      = fin_acc;
        raw_next.negative = neg_next;
        raw_next.zero     = fin_err || (mode_next == MODE_SKIP);
        raw_next.error    = fin_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            pend_reg      <= '0;
            err_reg       <= 1'b0;
            raw_valid_reg <= 1'b0;
            raw_reg       <= '0;
        end
        else
        begin
            if (take && in_data.last_char)
                raw_valid_reg <= 1'b1;
            else if (raw_ready)
                raw_valid_reg <= 1'b0;
            if (take)
            begin
                if (in_data.last_char)
                begin
                    mode_reg <= MODE_START;
                    acc_reg  <= '0;
                    neg_reg  <= 1'b0;
                    pend_reg <= '0;
                    err_reg  <= 1'b0;
                    raw_reg  <= raw_next;
                end
                else
                begin
                    mode_reg <= mode_next;
                    acc_reg  <= acc_next;
                    neg_reg  <= neg_next;
                    pend_reg <= pend_next;
                    err_reg  <= err_next;
                end
            end
        end
    end

    `ILP_ASSERT_NOW(a_err_forces_zero, raw_valid_reg && raw_reg.error, raw_reg.zero)
    `ILP_ASSERT_NEXT(a_last_restarts, take && in_data.last_char, mode_reg == MODE_START && acc_reg == '0)
    `ILP_ASSERT_NOW(a_skip_no_error, mode_reg == MODE_SKIP, !err_reg)

endmodule

[design/ilp_out_reg.sv]
// Sign apply, sign extension and output register of the integer literal parser.
// Depends on ilp_pkg and integer_literal_parser_defines.svh.
`include "integer_literal_parser_defines.svh"
module ilp_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           raw_valid,
    output logic                           raw_ready,
    input  ilp_pkg::ilp_raw_t              raw_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ilp_pkg::OUT_WIDTH-1:0]  out_value,
    output logic                           out_error
);

    localparam int VW = ilp_pkg::VALUE_WIDTH;
    localparam int OW = ilp_pkg::OUT_WIDTH;

    logic                 valid_reg;
    logic [OW-1:0]        value_reg, value_next;
    logic                 error_reg;
    logic signed [VW-1:0] signed_val;

    assign raw_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_error = error_reg;

    always_comb
    begin
        signed_val = raw_data.negative ? -raw_data.acc : raw_data.acc;
        value_next = raw_data.zero ? '0 : OW'(signed_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (raw_ready)
        begin
            valid_reg <= raw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw_ready && raw_valid)
        begin
            value_reg <= value_next;
            error_reg <= raw_data.error;
        end
    end

    `ILP_ASSERT_NOW(a_error_value_zero, valid_reg && error_reg, value_reg == '0)

endmodule

[design/integer_literal_parser.sv]
// Top level of the streaming integer literal parser (decimal, 0b binary, 0x hex).
// Depends on ilp_pkg, ilp_in_reg, ilp_parser and ilp_out_reg.
//
//   side    | tdata            | tlast      | tuser
//   s_axis  | [7:0] char_code  | last_char  | -
//   m_axis  | [63:0] value     | -          | [0] parse_error
//
// One character transfer per cycle while s_axis_tready is high; after the transfer of the
// last character the result passes the input, parse and output registers before
// m_axis_tvalid rises. The parse stage updates its state with a constant multiply by
// 10, 2 or 16 and one add. Reset clears all valid bits and the parse state.
// A stalled m_axis backs up the register chain; s_axis_tready drops only when a
// last character cannot hand its result on.
module integer_literal_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // char_code
    input  logic                          s_axis_tlast,  // last_char
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ilp_pkg::OUT_WIDTH-1:0] m_axis_tdata,  // value
    output logic [0:0]                    m_axis_tuser   // parse_error
);

    ilp_pkg::ilp_char_t s_char;
    ilp_pkg::ilp_char_t p_char;
    ilp_pkg::ilp_raw_t  raw;
    logic               p_valid, p_ready;
    logic               r_valid, r_ready;
    logic               err;

    assign s_char.char_code = s_axis_tdata;
    assign s_char.last_char = s_axis_tlast;
    assign m_axis_tuser     = err;

    ilp_in_reg u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_char),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_char)
    );

    ilp_parser u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_data   (p_char),
        .raw_valid (r_valid),
        .raw_ready (r_ready),
        .raw_data  (raw)
    );

    ilp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (r_valid),
        .raw_ready (r_ready),
        .raw_data  (raw),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_error (err)
    );

endmodule

[dv/integer_literal_parser_check.sv]
// Checker for the integer literal parser: watches both stream channels, predicts each
// literal's value and error flag from the accepted characters, and compares results.
// Depends on ilp_pkg for widths and character codes.
module integer_literal_parser_check
    import ilp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // char_code
    input  logic                 s_axis_tlast,   // last_char
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [OUT_WIDTH-1:0] m_axis_tdata,   // value
    input  logic [0:0]           m_axis_tuser,   // parse_error
    output int                   fail_count,
    output int                   results_pending,
    output int                   results_checked
);

    localparam int unsigned RADIX_BIN = 2;
    localparam int unsigned RADIX_DEC = 10;
    localparam int unsigned RADIX_HEX = 16;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_SIGNED,
        SCAN_SECOND,
        SCAN_DEC,
        SCAN_BIN,
        SCAN_HEX,
        SCAN_SKIP
    } scan_mode_t;

    typedef struct {
        logic [OUT_WIDTH-1:0] value;
        logic                 parse_error;
    } literal_result_t;

    literal_result_t         expected_literals[$];

    logic [VALUE_WIDTH-1:0]  lit_acc      = '0;
    logic                    lit_negative = 1'b0;
    scan_mode_t              lit_mode     = SCAN_START;
    logic [7:0]              lit_first    = '0;
    logic                    lit_bad      = 1'b0;

    function automatic logic [4:0] digit_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 5'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF)
            return 5'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UF)
            return 5'(c - CH_UA + 8'd10);
        return NO_DIGIT;
    endfunction

    function void clear_literal();
        lit_acc      = '0;
        lit_negative = 1'b0;
        lit_mode     = SCAN_START;
        lit_first    = '0;
        lit_bad      = 1'b0;
    endfunction

    // once a bad digit is seen the rest of the literal is ignored
    function void fold_digit(logic [7:0] c, int unsigned radix);
        logic [4:0] d;
        if (lit_bad)
            return;
        d = digit_value(c);
        if (d == NO_DIGIT || (radix == RADIX_BIN && d > 5'd1)) begin
            lit_bad = 1'b1;
            return;
        end
        lit_acc = lit_acc * VALUE_WIDTH'(radix) + VALUE_WIDTH'(d);
    endfunction

    function void take_char(logic [7:0] c, logic last);
        literal_result_t        res;
        logic [VALUE_WIDTH-1:0] v;
        case (lit_mode)
            SCAN_START:
                if (c == CH_MINUS) begin
                    lit_negative = 1'b1;
                    lit_mode     = SCAN_SIGNED;
                end else begin
                    lit_first = c;
                    lit_mode  = SCAN_SECOND;
                end
            SCAN_SIGNED:
            begin
                lit_first = c;
                lit_mode  = SCAN_SECOND;
            end
            SCAN_SECOND:
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    lit_mode = SCAN_DEC;
                    fold_digit(lit_first, RADIX_DEC);
                    fold_digit(c, RADIX_DEC);
                end else if (lit_first == CH_ZERO && c == CH_LB) begin
                    lit_mode = SCAN_BIN;
                end else if (lit_first == CH_ZERO && c == CH_LX) begin
                    lit_mode = SCAN_HEX;
                end else begin
                    lit_mode = SCAN_SKIP;
                end
            SCAN_DEC: fold_digit(c, RADIX_DEC);
            SCAN_BIN: fold_digit(c, RADIX_BIN);
            SCAN_HEX: fold_digit(c, RADIX_HEX);
            default: ;
        endcase
        if (!last)
            return;
        // a lone character after the optional sign is one decimal digit
        if (lit_mode == SCAN_SECOND)
            fold_digit(lit_first, RADIX_DEC);
        if (lit_bad || lit_mode == SCAN_SKIP)
            v = '0;
        else
            v = lit_negative ? -lit_acc : lit_acc;
        res.value       = OUT_WIDTH'($signed(v));
        res.parse_error = lit_bad;
        expected_literals.push_back(res);
        clear_literal();
    endfunction

    task report_mismatch(string what, logic [OUT_WIDTH-1:0] got, logic [OUT_WIDTH-1:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        literal_result_t want;
        if (!rst_n) begin
            clear_literal();
            expected_literals.delete();
            results_pending = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_literals.size() == 0) begin
                    report_mismatch("result with none pending", m_axis_tdata, '0);
                end else begin
                    want = expected_literals.pop_front();
                    if (m_axis_tdata !== want.value)
                        report_mismatch("value", m_axis_tdata, want.value);
                    if (m_axis_tuser[0] !== want.parse_error)
                        report_mismatch("parse_error", OUT_WIDTH'(m_axis_tuser),
                                        OUT_WIDTH'(want.parse_error));
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_char(s_axis_tdata, s_axis_tlast);
            results_pending = expected_literals.size();
        end
    end

endmodule

[dv/integer_literal_parser_test.sv]
// Testbench top for the integer literal parser: clock, reset, character stimulus and
// result backpressure, with the verdict taken from integer_literal_parser_check.
// Depends on ilp_pkg, integer_literal_parser and integer_literal_parser_check.
module integer_literal_parser_test;
    import ilp_pkg::*;

    localparam int    CYCLE_LIMIT     = 200000;
    localparam int    CHARS_PER_PHASE = 550;
    localparam int    LONG_HOLD       = 300;
    localparam int    DRAIN_CYCLES    = 10;
    localparam string HEX_CHARS       = "0123456789abcdefABCDEF";
    localparam string BAD_CHARS       = " gGz.+_-";
    localparam string ODD_SECONDS     = "BXz_-g.q";

    typedef enum int {
        LIT_DEC,
        LIT_BIN,
        LIT_HEX,
        LIT_PREFIX,
        LIT_NOISE
    } literal_kind_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_WIDTH-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    int  fail_count;
    int  results_pending;
    int  results_checked;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  long_hold_req = 1'b0;
    int  chars_sent    = 0;
    int  literals_sent = 0;
    int  cycle_count   = 0;

    logic [7:0] literal_buf[$];

    always #5 clk = ~clk;

    integer_literal_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    integer_literal_parser_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_literal();
        for (int i = 0; i < literal_buf.size(); i++)
            send_char(literal_buf[i], i == literal_buf.size() - 1);
        literals_sent++;
    endtask

    task automatic send_text(input string s);
        literal_buf.delete();
        for (int i = 0; i < s.len(); i++)
            literal_buf.push_back(s[i]);
        send_literal();
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    // mostly well-formed literals with random digits; some broken, odd-prefix or noise
    function automatic void build_random_literal();
        literal_kind_t kind;
        bit            broken;
        int            r;
        int            n;
        int            pos;
        r      = $urandom_range(99);
        kind   = r < 30 ? LIT_DEC : r < 55 ? LIT_BIN : r < 80 ? LIT_HEX :
                 r < 90 ? LIT_PREFIX : LIT_NOISE;
        broken = (kind != LIT_NOISE && kind != LIT_PREFIX && $urandom_range(4) == 0);
        literal_buf.delete();
        if (kind != LIT_NOISE && $urandom_range(9) < 3)
            literal_buf.push_back(CH_MINUS);
        case (kind)
            LIT_DEC:
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(21, 30) : $urandom_range(1, 19);
                repeat (n)
                    literal_buf.push_back(($urandom_range(9) == 0) ?
                        HEX_CHARS[$urandom_range(21, 10)] : 8'(CH_ZERO + $urandom_range(9)));
            end
            LIT_BIN:
            begin
                literal_buf.push_back(CH_ZERO);
                literal_buf.push_back(CH_LB);
                n = ($urandom_range(3) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
                repeat (n)
                    literal_buf.push_back(8'(CH_ZERO + $urandom_range(1)));
            end
            LIT_HEX:
            begin
                literal_buf.push_back(CH_ZERO);
                literal_buf.push_back(CH_LX);
                n = ($urandom_range(4) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 10);
                repeat (n)
                    literal_buf.push_back(HEX_CHARS[$urandom_range(21)]);
            end
            LIT_PREFIX:
            begin
                literal_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
                literal_buf.push_back(ODD_SECONDS[$urandom_range(ODD_SECONDS.len() - 1)]);
                repeat ($urandom_range(4))
                    literal_buf.push_back(8'($urandom));
            end
            default:
                repeat ($urandom_range(1, 6))
                    literal_buf.push_back(8'($urandom));
        endcase
        if (broken) begin
            pos = $urandom_range(literal_buf.size() - 1);
            case ($urandom_range(2))
                0: literal_buf[pos] = BAD_CHARS[$urandom_range(BAD_CHARS.len() - 1)];
                1: literal_buf[pos] = 8'($urandom_range(255, 128));
                default: literal_buf[pos] = 8'(CH_ZERO + $urandom_range(9, 2));
            endcase
        end
    endfunction

    initial
    begin
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                repeat (LONG_HOLD) begin
                    m_axis_tready <= 1'b0;
                    @(negedge clk);
                end
                long_hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycle_count, results_pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int phase_start;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send_text("7");
        send_text("A");
        send_text("g");
        send_text("-");
        send_text("-5");
        send_text("0b");
        send_text("0x");
        send_text("0b12");
        send_text("0zq");
        send_text("9F");
        send_text("-0xF");
        literal_buf = {8'h00};
        send_literal();
        literal_buf = {8'hFF};
        send_literal();
        wait_for_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 17 : 0;
            if (phase == 2)
                long_hold_req = 1'b1;
            phase_start = chars_sent;
            while (chars_sent - phase_start < CHARS_PER_PHASE) begin
                build_random_literal();
                send_literal();
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d literals in %0d character transfers, checked %0d results",
                 literals_sent, chars_sent, results_checked);
        $display("decimal, binary, hex, broken and noise literals under three stall mixes");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
